// ===== hdl/clc_pkg.sv =====
// Shared types and constants for the competitive learning cluster.
`timescale 1ns / 1ps
package clc_pkg;

    localparam int NEURONS_DEF = 2;
    localparam int DIMS_DEF    = 2;

    localparam int WORD_W  = 16;   // Q2.13 weight / sample
    localparam int RATE_W  = 16;   // Q0.16 learning rate
    localparam int FUNC_W  = 2;
    localparam int CFG_A_W = 1;
    localparam int OUT_D_W = 35;   // reported distance
    localparam int DIST_W  = 33;   // two squares of 16 bit magnitudes

    localparam logic [RATE_W-1:0] RATE_RESET   = 16'd39322;  // 0.6
    localparam logic [WORD_W-1:0] WEIGHT_RESET = 16'd4096;   // 0.5

    // item function codes
    localparam logic [FUNC_W-1:0] FUNC_TRAIN    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLASSIFY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EPOCH    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_RATE_START   = 1'b0;
    localparam logic [CFG_A_W-1:0] REG_WEIGHT_START = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic calc;    // latch own distance
        logic train;   // squared distance when set, absolute otherwise
        logic load;    // restart: all weights to start value
        logic upd;     // move the winner toward the sample
    } cell_ctrl_t;

endpackage

// ===== hdl/clc_cell.sv =====
// One neuron cell: weight storage, distance, winner compare and weight update.
`timescale 1ns / 1ps
module clc_cell #(
    parameter int DIMS     = clc_pkg::DIMS_DEF,
    parameter int IDX_W    = 1,
    parameter int CELL_IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  clc_pkg::cell_ctrl_t        ctrl,
    input  clc_pkg::word_t             sample_a,
    input  clc_pkg::word_t             sample_b,
    input  logic [clc_pkg::RATE_W-1:0] rate,
    input  clc_pkg::word_t             weight_init,
    input  logic [IDX_W-1:0]           win_idx,
    input  logic                       tin_valid,
    input  logic [clc_pkg::DIST_W-1:0] tin_dist,
    input  logic [IDX_W-1:0]           tin_idx,
    output logic                       tout_valid,
    output logic [clc_pkg::DIST_W-1:0] tout_dist,
    output logic [IDX_W-1:0]           tout_idx
);
    import clc_pkg::*;

    word_t               x [2];
    word_t               w_reg [DIMS];
    word_t               w_upd [DIMS];
    logic [DIST_W-1:0]   term [DIMS];
    logic [DIST_W-1:0]   dist_sum;
    logic [DIST_W-1:0]   dist_reg;
    logic                tok_valid_reg;
    logic [DIST_W-1:0]   tok_dist_reg;
    logic [IDX_W-1:0]    tok_idx_reg;
    logic                take;
    logic                is_win;

    assign x[0] = sample_a;
    assign x[1] = sample_b;

    for (genvar g = 0; g < DIMS; g++) begin : g_dim
        logic [WORD_W:0]          diff;
        logic [WORD_W:0]          neg;
        logic [WORD_W-1:0]        mag;
        logic [2*WORD_W-1:0]      sq;
        logic signed [WORD_W:0]   dx;
        logic signed [33:0]       prod;
        logic signed [17:0]       step;
        logic [17:0]              nw;

        // distance term
        assign diff = {w_reg[g][WORD_W-1], w_reg[g]} - {x[g][WORD_W-1], x[g]};
        assign neg  = -diff;
        assign mag  = diff[WORD_W] ? neg[WORD_W-1:0] : diff[WORD_W-1:0];
        assign sq   = mag * mag;
        assign term[g] = ctrl.train ? DIST_W'(sq) : DIST_W'(mag);

        // step = floor(rate * (x - w) / 2^16), saturated sum
        assign dx   = $signed({x[g][WORD_W-1], x[g]}) - $signed({w_reg[g][WORD_W-1], w_reg[g]});
        assign prod = $signed({1'b0, rate}) * dx;
        assign step = prod[33:16];
        assign nw   = {{2{w_reg[g][WORD_W-1]}}, w_reg[g]} + step;
        assign w_upd[g] = (nw[17:15] == 3'b000 || nw[17:15] == 3'b111) ? nw[15:0]
                        : (nw[17] ? 16'h8000 : 16'h7fff);
    end

    always_comb begin
        dist_sum = '0;
        for (int i = 0; i < DIMS; i++) begin
            dist_sum = dist_sum + term[i];
        end
    end

    // later neuron wins ties; the first cell always takes the token
    assign take   = (CELL_IDX == 0) || (dist_reg <= tin_dist);
    assign is_win = ctrl.upd && (win_idx == IDX_W'(CELL_IDX));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIMS; i++) begin
                w_reg[i] <= WEIGHT_RESET;
            end
        end else if (ctrl.load) begin
            for (int i = 0; i < DIMS; i++) begin
                w_reg[i] <= weight_init;
            end
        end else if (is_win) begin
            for (int i = 0; i < DIMS; i++) begin
                w_reg[i] <= w_upd[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.calc) begin
            dist_reg <= dist_sum;
        end
        if (tin_valid) begin
            tok_dist_reg <= take ? dist_reg : tin_dist;
            tok_idx_reg  <= take ? IDX_W'(CELL_IDX) : tin_idx;
        end
    end

    assign tout_valid = tok_valid_reg;
    assign tout_dist  = tok_dist_reg;
    assign tout_idx   = tok_idx_reg;

endmodule

// ===== hdl/competitive_learning_cluster.sv =====
// Top level of the winner-take-all competitive learning cluster.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_*: one word carries s_func and two Q2.13 sample
//   components. Train (0) picks the neuron with least squared distance and
//   moves it toward the sample; classify (1) uses the absolute-difference
//   sum; epoch (2) halves the rate; restart (3) reloads weights and rate
//   from the config registers. Every word yields one result word on m_*.
//   Config port: cfg_wr_en/cfg_addr/cfg_wdata writes rate_start (0) or
//   weight_start (1); write only while idle. Values take effect at restart.
//   Train and classify pass the distance state, then the winner token
//   walks the chain of neuron cells one cell per cycle; train adds the
//   update state. Epoch and restart go straight to the output register.
//   One word in flight; s_ready returns with m_valid, so a new word is
//   accepted only once the last result is loaded into m_*.
//   A result held by a stalled receiver does not block the next accept;
//   a second result waits in the core until the output register frees.
//   Reset (aresetn low, synchronous): weights 0.5, rate 0.6, no result.
module competitive_learning_cluster #(
    parameter int NEURONS = clc_pkg::NEURONS_DEF,
    parameter int DIMS    = clc_pkg::DIMS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config write port
    input  logic                         cfg_wr_en,
    input  logic [clc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [clc_pkg::WORD_W-1:0]   cfg_wdata,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [clc_pkg::FUNC_W-1:0]   s_func,
    input  logic signed [clc_pkg::WORD_W-1:0] s_sample_a,
    input  logic signed [clc_pkg::WORD_W-1:0] s_sample_b,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_winner,
    output logic [clc_pkg::OUT_D_W-1:0]  m_best_distance
);
    import clc_pkg::*;

    localparam int IDX_W = $clog2(NEURONS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIST = 5'b00010,
        S_SCAN = 5'b00100,
        S_UPD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg;
    word_t                 samp_a_reg, samp_b_reg;
    logic [RATE_W-1:0]     rate_now_reg, rate_now_next;
    logic [RATE_W-1:0]     rate_start_reg;
    word_t                 weight_start_reg;
    logic                  tok_start_reg;
    logic [IDX_W-1:0]      res_idx_reg;
    logic [DIST_W-1:0]     res_dist_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_winner_reg;
    logic [OUT_D_W-1:0]    m_dist_reg;

    logic                  accept;
    logic                  out_load;
    cell_ctrl_t            ctrl;

    // token chain: index k feeds cell k
    logic                  ch_valid [NEURONS+1];
    logic [DIST_W-1:0]     ch_dist  [NEURONS+1];
    logic [IDX_W-1:0]      ch_idx   [NEURONS+1];

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_func == FUNC_TRAIN || s_func == FUNC_CLASSIFY) begin
                        state_next = S_DIST;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIST: state_next = S_SCAN;
            S_SCAN: begin
                if (ch_valid[NEURONS]) begin
                    state_next = (func_reg == FUNC_TRAIN) ? S_UPD : S_OUT;
                end
            end
            S_UPD: state_next = S_OUT;
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        rate_now_next = rate_now_reg;
        if (accept && s_func == FUNC_EPOCH) begin
            rate_now_next = {1'b0, rate_now_reg[RATE_W-1:1]};
        end else if (accept && s_func == FUNC_RESTART) begin
            rate_now_next = rate_start_reg;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign ctrl.calc  = (state_reg == S_DIST);
    assign ctrl.train = (func_reg == FUNC_TRAIN);
    assign ctrl.load  = accept && (s_func == FUNC_RESTART);
    assign ctrl.upd   = (state_reg == S_UPD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            rate_now_reg     <= RATE_RESET;
            rate_start_reg   <= RATE_RESET;
            weight_start_reg <= WEIGHT_RESET;
            tok_start_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rate_now_reg  <= rate_now_next;
            tok_start_reg <= (state_reg == S_DIST);
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_RATE_START:   rate_start_reg   <= cfg_wdata;
                    REG_WEIGHT_START: weight_start_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            samp_a_reg   <= s_sample_a;
            samp_b_reg   <= s_sample_b;
            res_idx_reg  <= '0;
            res_dist_reg <= '0;
        end else if (state_reg == S_SCAN && ch_valid[NEURONS]) begin
            res_idx_reg  <= ch_idx[NEURONS];
            res_dist_reg <= ch_dist[NEURONS];
        end
        if (out_load) begin
            m_winner_reg <= res_idx_reg[0];
            m_dist_reg   <= OUT_D_W'(res_dist_reg);
        end
    end

    // chain of neuron cells
    assign ch_valid[0] = tok_start_reg;
    assign ch_dist[0]  = '0;
    assign ch_idx[0]   = '0;

    for (genvar n = 0; n < NEURONS; n++) begin : g_cell
        clc_cell #(
            .DIMS     (DIMS),
            .IDX_W    (IDX_W),
            .CELL_IDX (n)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .sample_a    (samp_a_reg),
            .sample_b    (samp_b_reg),
            .rate        (rate_now_reg),
            .weight_init (weight_start_reg),
            .win_idx     (res_idx_reg),
            .tin_valid   (ch_valid[n]),
            .tin_dist    (ch_dist[n]),
            .tin_idx     (ch_idx[n]),
            .tout_valid  (ch_valid[n+1]),
            .tout_dist   (ch_dist[n+1]),
            .tout_idx    (ch_idx[n+1])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_winner        = m_winner_reg;
    assign m_best_distance = m_dist_reg;

endmodule

// ===== hdl/clc_checker.sv =====
// Port-level checks for the competitive learning cluster, bound to the top level.
`timescale 1ns / 1ps
module clc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_winner,
    input logic [clc_pkg::OUT_D_W-1:0] m_best_distance
);
    import clc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_winner) && $stable(m_best_distance))
        else $error("result word changed while stalled");

    // one word in flight: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a word while busy");

    // a new result is only loaded out of a busy cycle
    a_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work in progress");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind competitive_learning_cluster clc_checker u_clc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_winner        (m_winner),
    .m_best_distance (m_best_distance)
);
